// ===== rtl/rational_arith_unit_defines.svh =====
// Assertion macros for the rational arithmetic unit.
// Used by rau_back, the RTL file that carries assertions; needs clk and rst_n in scope.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RAU_ASSERT_IMP(lbl, ante, cons, msg)
`define RAU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_MUL = 2'd1;
    localparam op_t OP_EQ  = 2'd2;
    localparam op_t OP_INC = 2'd3;

    typedef struct packed {
        logic is_eq_op;
        logic eq;
        logic bad;
        logic sn;
        logic sd;
    } rau_flags_t;
endpackage

// ===== rtl/rau_if.sv =====
// Valid/ready channel interfaces of the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_in_if import rau_pkg::*; #(parameter int W = OPERAND_WIDTH_DEF);
    logic                valid;
    logic                ready;
    op_t                 op;
    logic signed [W-1:0] a_num;
    logic signed [W-1:0] a_den;
    logic signed [W-1:0] b_num;
    logic signed [W-1:0] b_den;

    modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic signed [RES_DEN_W-1:0] res_den;
    logic                        is_equal;
    logic                        bad_den;

    modport source (output valid, res_num, res_den, is_equal, bad_den, input ready);
    modport sink   (input valid, res_num, res_den, is_equal, bad_den, output ready);
endinterface

// ===== rtl/rau_front.sv =====
// Front end: takes items, multiplies, classifies into sign/magnitude fractions.
// Depends on rau_pkg and rau_if.
module rau_front import rau_pkg::*; #(
    parameter int W  = OPERAND_WIDTH_DEF,
    parameter int MW = 2 * W + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    rau_in_if.sink           req,
    output logic             push,
    input  logic             push_ready,
    output rau_flags_t       push_flags,
    output logic [MW-1:0]    push_mn,
    output logic [MW-1:0]    push_md
);
    localparam int PW = 2 * W;

    logic                v1_reg, v2_reg;
    op_t                 op1_reg, op2_reg;
    logic                bad1_reg, bad2_reg;
    logic signed [W-1:0] an1_reg, ad1_reg, bn1_reg, bd1_reg;
    logic signed [W-1:0] an2_reg, ad2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, pd_reg, pn_reg;

    logic                adv2;
    logic                take;
    logic signed [W-1:0] ad_in, bd_in;

    assign push = v2_reg && push_ready;
    assign adv2 = !v2_reg || push_ready;
    assign req.ready = !v1_reg || adv2;
    assign take = req.valid && req.ready;
    assign ad_in = (req.a_den == '0) ? W'(1) : req.a_den;
    assign bd_in = (req.b_den == '0) ? W'(1) : req.b_den;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                v1_reg <= req.valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op1_reg  <= req.op;
            bad1_reg <= (req.a_den == '0) || (req.b_den == '0);
            an1_reg  <= req.a_num;
            ad1_reg  <= ad_in;
            bn1_reg  <= req.b_num;
            bd1_reg  <= bd_in;
        end
        if (adv2 && v1_reg)
        begin
            op2_reg  <= op1_reg;
            bad2_reg <= bad1_reg;
            an2_reg  <= an1_reg;
            ad2_reg  <= ad1_reg;
            p1_reg   <= PW'(an1_reg) * PW'(bd1_reg);
            p2_reg   <= PW'(ad1_reg) * PW'(bn1_reg);
            pd_reg   <= PW'(ad1_reg) * PW'(bd1_reg);
            pn_reg   <= PW'(an1_reg) * PW'(bn1_reg);
        end
    end

    logic [MW-1:0]      m1, m2, mpn, mpd, msum, mad;
    logic signed [W:0]  sum;
    logic               s1, s2;
    logic [MW-1:0]      mn;
    logic               sn, sd;

    assign s1   = p1_reg[PW-1];
    assign s2   = p2_reg[PW-1];
    assign m1   = MW'(s1 ? PW'(-p1_reg) : PW'(p1_reg));
    assign m2   = MW'(s2 ? PW'(-p2_reg) : PW'(p2_reg));
    assign mpn  = MW'(pn_reg[PW-1] ? PW'(-pn_reg) : PW'(pn_reg));
    assign mpd  = MW'(pd_reg[PW-1] ? PW'(-pd_reg) : PW'(pd_reg));
    assign sum  = (W+1)'(an2_reg) + (W+1)'(ad2_reg);
    assign msum = MW'($unsigned(sum[W] ? -sum : sum));
    assign mad  = MW'($unsigned(ad2_reg[W-1] ? -ad2_reg : ad2_reg));

    always_comb
    begin
        mn = '0;
        sn = 1'b0;
        sd = 1'b0;
        push_md = '0;
        unique case (op2_reg)
            OP_ADD:
            begin
                sd = pd_reg[PW-1];
                push_md = mpd;
                if (s1 == s2)
                begin
                    mn = m1 + m2;
                    sn = s1;
                end
                else if (m1 >= m2)
                begin
                    mn = m1 - m2;
                    sn = s1;
                end
                else
                begin
                    mn = m2 - m1;
                    sn = s2;
                end
            end
            OP_MUL:
            begin
                mn = mpn;
                sn = pn_reg[PW-1];
                sd = pd_reg[PW-1];
                push_md = mpd;
            end
            OP_EQ:
            begin
                push_md = MW'(1);
            end
            OP_INC:
            begin
                mn = msum;
                sn = sum[W];
                sd = ad2_reg[W-1];
                push_md = mad;
            end
            default:
            begin
                mn = '0;
            end
        endcase
        if (mn == '0)
            sn = 1'b0;
        if (sn && sd)
        begin
            sn = 1'b0;
            sd = 1'b0;
        end
        push_mn = mn;
        push_flags.is_eq_op = (op2_reg == OP_EQ);
        push_flags.eq       = (op2_reg == OP_EQ) && (p1_reg == p2_reg);
        push_flags.bad      = bad2_reg;
        push_flags.sn       = sn;
        push_flags.sd       = sd;
    end
endmodule

// ===== rtl/rau_queue.sv =====
// Short register queue between front and back end.
// Depends on rau_pkg.
module rau_queue import rau_pkg::*; #(
    parameter int DW    = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    output logic          wr_ready,
    input  logic [DW-1:0] wr_data,
    input  logic          rd,
    output logic          rd_valid,
    output logic [DW-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && wr_ready)
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd && rd_valid)
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + CNT_W'(wr && wr_ready) - CNT_W'(rd && rd_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== rtl/rau_back.sv =====
// Back end: binary gcd, two restoring divisions by the gcd, output register.
// Depends on rau_pkg, rau_if and rational_arith_unit_defines.svh.
`include "rational_arith_unit_defines.svh"
module rau_back import rau_pkg::*; #(
    parameter int MW = 2 * OPERAND_WIDTH_DEF + 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  rau_flags_t    q_flags,
    input  logic [MW-1:0] q_mn,
    input  logic [MW-1:0] q_md,
    rau_out_if.source     rsp
);
    localparam int KW = $clog2(MW + 1);
    localparam int EW = MW + RES_NUM_W;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GCD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg;
    rau_flags_t    fl_reg;
    logic [MW-1:0] x_reg, y_reg, g_reg;
    logic [MW-1:0] qn_reg, qd_reg, rn_reg, rd_reg;
    logic [KW-1:0] k_reg, cnt_reg;
    logic          ov_reg;
    logic signed [RES_NUM_W-1:0] onum_reg;
    logic signed [RES_DEN_W-1:0] oden_reg;
    logic          oeq_reg, obad_reg;

    logic          out_free;
    logic [MW:0]   rn_sh, rd_sh;
    logic          bn_ge, bd_ge;
    logic [EW-1:0] qn_ext, qd_ext, nn, nd;

    assign out_free = !ov_reg || rsp.ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign rn_sh    = {rn_reg, qn_reg[MW-1]};
    assign rd_sh    = {rd_reg, qd_reg[MW-1]};
    assign bn_ge    = rn_sh >= {1'b0, g_reg};
    assign bd_ge    = rd_sh >= {1'b0, g_reg};
    assign qn_ext   = EW'(qn_reg);
    assign qd_ext   = EW'(qd_reg);
    assign nn       = fl_reg.sn ? EW'(0) - qn_ext : qn_ext;
    assign nd       = fl_reg.sd ? EW'(0) - qd_ext : qd_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        if (q_flags.is_eq_op || q_mn == '0)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_GCD;
                    end
                ST_GCD:
                    if (x_reg[0] && y_reg[0] && x_reg == y_reg)
                        state_reg <= ST_DIV;
                ST_DIV:
                    if (cnt_reg == KW'(MW - 1))
                        state_reg <= ST_DONE;
                ST_DONE:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    fl_reg  <= q_flags;
                    x_reg   <= q_mn;
                    y_reg   <= q_md;
                    k_reg   <= '0;
                    cnt_reg <= '0;
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    qn_reg  <= q_flags.is_eq_op ? '0 : q_mn;
                    qd_reg  <= (q_flags.is_eq_op || q_mn == '0) ? MW'(1) : q_md;
                end
            ST_GCD:
            begin
                priority if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                    x_reg <= x_reg >> 1;
                else if (!y_reg[0])
                    y_reg <= y_reg >> 1;
                else if (x_reg == y_reg)
                    g_reg <= x_reg << k_reg;
                else if (x_reg > y_reg)
                    x_reg <= x_reg - y_reg;
                else
                    y_reg <= y_reg - x_reg;
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                rn_reg  <= bn_ge ? MW'(rn_sh - {1'b0, g_reg}) : MW'(rn_sh);
                rd_reg  <= bd_ge ? MW'(rd_sh - {1'b0, g_reg}) : MW'(rd_sh);
                qn_reg  <= {qn_reg[MW-2:0], bn_ge};
                qd_reg  <= {qd_reg[MW-2:0], bd_ge};
            end
            ST_DONE:
                if (out_free)
                begin
                    onum_reg <= nn[RES_NUM_W-1:0];
                    oden_reg <= nd[RES_DEN_W-1:0];
                    oeq_reg  <= fl_reg.eq;
                    obad_reg <= fl_reg.bad;
                end
            default:
                cnt_reg <= '0;
        endcase
    end

    assign rsp.valid    = ov_reg;
    assign rsp.res_num  = onum_reg;
    assign rsp.res_den  = oden_reg;
    assign rsp.is_equal = oeq_reg;
    assign rsp.bad_den  = obad_reg;

    `RAU_ASSERT_IMP(a_gcd_nonzero, state_reg == ST_GCD, x_reg != '0 && y_reg != '0, "gcd operand zero")
    `RAU_ASSERT_IMP(a_div_nonzero, state_reg == ST_DIV, g_reg != '0, "divisor zero")
    `RAU_ASSERT_NXT(a_done_out, state_reg == ST_DONE && out_free, ov_reg, "result not shown")
    `RAU_ASSERT_IMP(a_pop_idle, q_pop, state_reg == ST_IDLE && !(state_reg == ST_DONE), "pop out of idle")
endmodule

// ===== rtl/rational_arith_unit.sv =====
// Rational arithmetic unit: add, multiply, equality test, increment with gcd reduction.
// Front end: operand register and product register feed a short queue to the back end.
// The back end pops the next item only in idle, after the binary gcd loop and the MW-step
// dividers (MW = 2*OPERAND_WIDTH+1, 33 at width 16); equality and zero numerator skip both.
// Reset: rst_n asynchronous, active low; clears valids, queue and sequencer.
// Depends on rau_pkg, rau_if, rau_front, rau_queue, rau_back.
module rational_arith_unit import rau_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rau_in_if.sink    req,
    rau_out_if.source rsp
);
    localparam int MW = 2 * OPERAND_WIDTH + 1;
    localparam int FW = $bits(rau_flags_t);
    localparam int DW = FW + 2 * MW;

    logic          push, push_ready, q_valid, q_pop;
    rau_flags_t    push_flags, q_flags;
    logic [MW-1:0] push_mn, push_md, q_mn, q_md;
    logic [DW-1:0] q_data;

    rau_front #(.W(OPERAND_WIDTH), .MW(MW)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .push(push), .push_ready(push_ready),
        .push_flags(push_flags), .push_mn(push_mn), .push_md(push_md)
    );

    rau_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr(push), .wr_ready(push_ready), .wr_data({push_flags, push_mn, push_md}),
        .rd(q_pop), .rd_valid(q_valid), .rd_data(q_data)
    );

    assign q_flags = q_data[DW-1 -: FW];
    assign q_mn    = q_data[2*MW-1 -: MW];
    assign q_md    = q_data[MW-1:0];

    rau_back #(.MW(MW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop),
        .q_flags(q_flags), .q_mn(q_mn), .q_md(q_md),
        .rsp(rsp)
    );
endmodule
